### sv/diagonal_line_stepper_top_macros.svh
// Assertion macros for the diagonal line stepper.
`ifndef DIAGONAL_LINE_STEPPER_TOP_MACROS_SVH
`define DIAGONAL_LINE_STEPPER_TOP_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define DLS_ASSERT_SAME(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define DLS_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/dls_pkg.sv
// Shared types, constants and helpers of the diagonal line stepper.
package dls_pkg;

  localparam int POS_W      = 24;
  localparam int STEP_W     = 16;
  localparam int LIMIT_W    = 24;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam int DIR_W      = 3;
  localparam int DIV_W      = 25;
  localparam int QUO_W      = 17;
  localparam int SLOPE_W    = 18;
  localparam int OFS_W      = 26;
  localparam int CRN_W      = 26;
  localparam int MUL_W      = 27;
  localparam int PROD_W     = 54;
  localparam int DIST_W     = 52;
  localparam int DEV_W      = 27;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;

  localparam logic [CFG_ADDR_W-1:0] REG_STEP_SIZE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_STOP_LIMIT = 2'd1;

  localparam logic [STEP_W-1:0]  STEP_RESET  = 16'd256;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd512;

  localparam logic [DIR_W-1:0] DIR_NONE = 3'd4;

  localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = -24'sh800000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_OFS_MUL,
    S_OFS,
    S_CORNER,
    S_PICK,
    S_OUT
  } dls_state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } dls_div_req_t;

  // Corner 1 and 2 step +x, corners 2 and 3 step +y.
  function automatic logic plus_x(input logic [1:0] k);
    plus_x = (k == 2'd1) || (k == 2'd2);
  endfunction

  function automatic logic plus_y(input logic [1:0] k);
    plus_y = k[1];
  endfunction

  // Pen coordinate moved by one step in the given sense, full width.
  function automatic logic signed [CRN_W-1:0] corner(input logic signed [POS_W-1:0] pen,
                                                    input logic [STEP_W-1:0] st,
                                                    input logic plus);
    logic signed [CRN_W-1:0] p_ext;
    logic signed [CRN_W-1:0] s_ext;
    p_ext = {{(CRN_W-POS_W){pen[POS_W-1]}}, pen};
    s_ext = $signed({{(CRN_W-STEP_W){1'b0}}, st});
    corner = plus ? (p_ext + s_ext) : (p_ext - s_ext);
  endfunction

  // Clamp a corner coordinate into the pen range.
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [CRN_W-1:0] v);
    if (v > $signed({{(CRN_W-POS_W){1'b0}}, POS_MAX})) sat_pos = POS_MAX;
    else if (v < $signed({{(CRN_W-POS_W){1'b1}}, POS_MIN})) sat_pos = POS_MIN;
    else sat_pos = v[POS_W-1:0];
  endfunction

endpackage

### sv/diagonal_line_stepper_top.sv
// Top level of the diagonal line stepper: sequencer, state and datapath.
//
//  channel | dir | handshake          | payload
//  in      | in  | in_tvalid/tready   | tdata: target_x, target_y
//  out     | out | out_tvalid/tready  | tdata: step_dir, pos_x, pos_y; tuser: done_res
//  cfg     | in  | cfg_we             | cfg_addr, cfg_wdata
//
// An item goes straight to the output when the target is reached. A step rates
// the four corners on the shared multiplier; the first step toward a new
// target first finds the slope on the one-bit-per-cycle slope divider
// (17 quotient bits) and the offset. Either then waits for the output.
// Reset is synchronous, active low. in_tready is low from acceptance until the
// result transfer completes.
module diagonal_line_stepper_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [dls_pkg::IN_DATA_W-1:0]        in_tdata,   // target_x, target_y
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [dls_pkg::OUT_DATA_W-1:0]       out_tdata,  // step_dir, pos_x, pos_y, zero pad
  output logic                                 out_tuser,  // done_res
  input  logic                                 cfg_we,
  input  logic [dls_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [dls_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int PW = dls_pkg::POS_W;

  dls_pkg::dls_state_t state_r, state_nxt;

  logic [dls_pkg::STEP_W-1:0]         step_r;
  logic [dls_pkg::LIMIT_W-1:0]        limit_r;
  logic signed [PW-1:0]               tx_r, ty_r;
  logic signed [PW-1:0]               pen_x_r, pen_y_r;
  logic                               fit_pend_r;
  logic signed [dls_pkg::SLOPE_W-1:0] slope_r;
  logic signed [dls_pkg::OFS_W-1:0]   ofs_r;
  logic                               on_x_r;
  logic                               neg_r;
  logic [1:0]                         k_r;
  logic [1:0]                         ph_r;
  logic [dls_pkg::DIST_W-1:0]         acc_r;
  logic [dls_pkg::DIST_W-1:0]         s1_dist_r, s2_dist_r;
  logic [dls_pkg::DEV_W-1:0]          s1_dev_r, s2_dev_r;
  logic [1:0]                         s1_k_r, s2_k_r;
  logic                               s2_val_r;
  logic                               out_done_r;
  logic [dls_pkg::DIR_W-1:0]          out_dir_r;

  logic signed [PW:0]                 dx, dy;
  logic [PW:0]                        dxm, dym;
  logic [PW+1:0]                      l1;
  logic                               reached;
  logic                               on_x_new;
  logic                               div_done;
  logic [dls_pkg::QUO_W-1:0]          div_quo;
  dls_pkg::dls_div_req_t              div_req;
  logic signed [dls_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic signed [dls_pkg::PROD_W-1:0]  prod;
  logic signed [dls_pkg::PROD_W-1:0]  prod_rnd;
  logic signed [dls_pkg::OFS_W-1:0]   prod_q;
  logic signed [dls_pkg::CRN_W-1:0]   cx, cy, cmaj, cmin;
  logic signed [dls_pkg::MUL_W-1:0]   ex, ey;
  logic signed [dls_pkg::DEV_W:0]     dev_s;
  logic [dls_pkg::DEV_W-1:0]          dev;
  logic [1:0]                         pick;
  logic signed [dls_pkg::CRN_W-1:0]   pick_x, pick_y;
  logic signed [PW-1:0]               tmaj, tmin;

  // Distance to target and fit choice
  assign dx       = {tx_r[PW-1], tx_r} - {pen_x_r[PW-1], pen_x_r};
  assign dy       = {ty_r[PW-1], ty_r} - {pen_y_r[PW-1], pen_y_r};
  assign dxm      = dx[PW] ? (PW+1)'(0) - dx : dx;
  assign dym      = dy[PW] ? (PW+1)'(0) - dy : dy;
  assign l1       = {1'b0, dxm} + {1'b0, dym};
  assign reached  = l1 <= {2'b00, limit_r};
  assign on_x_new = dym <= dxm;

  // Divider request on the first step toward a target
  always_comb begin
    div_req.start = (state_r == dls_pkg::S_CHECK) && !reached && fit_pend_r;
    div_req.num   = on_x_new ? dym : dxm;
    div_req.den   = on_x_new ? dxm : dym;
  end

  dls_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Current corner and its offsets from the target
  assign cx   = dls_pkg::corner(pen_x_r, step_r, dls_pkg::plus_x(k_r));
  assign cy   = dls_pkg::corner(pen_y_r, step_r, dls_pkg::plus_y(k_r));
  assign cmaj = on_x_r ? cx : cy;
  assign cmin = on_x_r ? cy : cx;
  assign ex   = {{(dls_pkg::MUL_W-PW){tx_r[PW-1]}}, tx_r} - {cx[dls_pkg::CRN_W-1], cx};
  assign ey   = {{(dls_pkg::MUL_W-PW){ty_r[PW-1]}}, ty_r} - {cy[dls_pkg::CRN_W-1], cy};
  assign tmaj = on_x_r ? tx_r : ty_r;
  assign tmin = on_x_r ? ty_r : tx_r;

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == dls_pkg::S_OFS_MUL) begin
      mul_a = {{(dls_pkg::MUL_W-dls_pkg::SLOPE_W){slope_r[dls_pkg::SLOPE_W-1]}}, slope_r};
      mul_b = {{(dls_pkg::MUL_W-PW){tmaj[PW-1]}}, tmaj};
    end else if (state_r == dls_pkg::S_CORNER) begin
      case (ph_r)
        2'd0: begin
          mul_a = ex;
          mul_b = ex;
        end
        2'd1: begin
          mul_a = ey;
          mul_b = ey;
        end
        2'd2: begin
          mul_a = {{(dls_pkg::MUL_W-dls_pkg::SLOPE_W){slope_r[dls_pkg::SLOPE_W-1]}}, slope_r};
          mul_b = {cmaj[dls_pkg::CRN_W-1], cmaj};
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  dls_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Round the Q16 product half up to whole units
  assign prod_rnd = prod + dls_pkg::PROD_W'(32768);
  assign prod_q   = prod_rnd[dls_pkg::OFS_W+15:16];

  // Deviation of the corner from the guide line
  assign dev_s = {{2{cmin[dls_pkg::CRN_W-1]}}, cmin}
               - {{2{prod_q[dls_pkg::OFS_W-1]}}, prod_q}
               - {{2{ofs_r[dls_pkg::OFS_W-1]}}, ofs_r};
  assign dev   = dev_s[dls_pkg::DEV_W] ? dls_pkg::DEV_W'(0) - dev_s[dls_pkg::DEV_W-1:0]
                                       : dev_s[dls_pkg::DEV_W-1:0];

  // Final choice between the two nearest corners
  assign pick   = (s1_dev_r < s2_dev_r) ? s1_k_r : s2_k_r;
  assign pick_x = dls_pkg::corner(pen_x_r, step_r, dls_pkg::plus_x(pick));
  assign pick_y = dls_pkg::corner(pen_y_r, step_r, dls_pkg::plus_y(pick));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dls_pkg::S_IDLE:    if (in_tvalid) state_nxt = dls_pkg::S_CHECK;
      dls_pkg::S_CHECK: begin
        if (reached) state_nxt = dls_pkg::S_OUT;
        else if (fit_pend_r) state_nxt = dls_pkg::S_DIV;
        else state_nxt = dls_pkg::S_CORNER;
      end
      dls_pkg::S_DIV:     if (div_done) state_nxt = dls_pkg::S_OFS_MUL;
      dls_pkg::S_OFS_MUL: state_nxt = dls_pkg::S_OFS;
      dls_pkg::S_OFS:     state_nxt = dls_pkg::S_CORNER;
      dls_pkg::S_CORNER:  if (ph_r == 2'd3 && k_r == 2'd3) state_nxt = dls_pkg::S_PICK;
      dls_pkg::S_PICK:    state_nxt = dls_pkg::S_OUT;
      dls_pkg::S_OUT:     if (out_tready) state_nxt = dls_pkg::S_IDLE;
      default:            state_nxt = dls_pkg::S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_tready  = (state_r == dls_pkg::S_IDLE);
    out_tvalid = (state_r == dls_pkg::S_OUT);
  end

  assign out_tuser = out_done_r;
  assign out_tdata = {5'd0, pen_y_r, pen_x_r, out_dir_r};

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= dls_pkg::S_IDLE;
      step_r     <= dls_pkg::STEP_RESET;
      limit_r    <= dls_pkg::LIMIT_RESET;
      pen_x_r    <= '0;
      pen_y_r    <= '0;
      fit_pend_r <= 1'b1;
      slope_r    <= '0;
      ofs_r      <= '0;
      on_x_r     <= 1'b0;
      k_r        <= '0;
      ph_r       <= '0;
      s2_val_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          dls_pkg::REG_STEP_SIZE:  step_r  <= cfg_wdata[dls_pkg::STEP_W-1:0];
          dls_pkg::REG_STOP_LIMIT: limit_r <= cfg_wdata[dls_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (state_r == dls_pkg::S_CHECK) begin
        k_r  <= '0;
        ph_r <= '0;
        if (reached) begin
          fit_pend_r <= 1'b1;
        end else if (fit_pend_r) begin
          on_x_r <= on_x_new;
        end
      end
      if (state_r == dls_pkg::S_DIV && div_done) begin
        slope_r    <= neg_r ? dls_pkg::SLOPE_W'(0) - {1'b0, div_quo} : {1'b0, div_quo};
        fit_pend_r <= 1'b0;
      end
      if (state_r == dls_pkg::S_OFS) begin
        ofs_r <= {{(dls_pkg::OFS_W-PW){tmin[PW-1]}}, tmin} - prod_q;
      end
      if (state_r == dls_pkg::S_CORNER) begin
        ph_r <= ph_r + 2'd1;
        if (ph_r == 2'd3) begin
          k_r <= k_r + 2'd1;
          if (k_r == 2'd0) s2_val_r <= 1'b0;
          else s2_val_r <= 1'b1;
        end
      end
      if (state_r == dls_pkg::S_PICK) begin
        pen_x_r <= dls_pkg::sat_pos(pick_x);
        pen_y_r <= dls_pkg::sat_pos(pick_y);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      tx_r <= in_tdata[PW-1:0];
      ty_r <= in_tdata[2*PW-1:PW];
    end
    if (div_req.start) begin
      neg_r <= dx[PW] ^ dy[PW];
    end
    if (state_r == dls_pkg::S_CHECK) begin
      out_done_r <= 1'b1;
      out_dir_r  <= dls_pkg::DIR_NONE;
    end
    if (state_r == dls_pkg::S_PICK) begin
      out_done_r <= 1'b0;
      out_dir_r  <= {1'b0, pick};
    end
    // Accumulate squared distance, then rank the corner
    if (state_r == dls_pkg::S_CORNER) begin
      case (ph_r)
        2'd1: acc_r <= prod[dls_pkg::DIST_W-1:0];
        2'd2: acc_r <= acc_r + prod[dls_pkg::DIST_W-1:0];
        2'd3: begin
          if (k_r == 2'd0) begin
            s1_dist_r <= acc_r;
            s1_dev_r  <= dev;
            s1_k_r    <= k_r;
          end else if (s1_dist_r > acc_r) begin
            s2_dist_r <= s1_dist_r;
            s2_dev_r  <= s1_dev_r;
            s2_k_r    <= s1_k_r;
            s1_dist_r <= acc_r;
            s1_dev_r  <= dev;
            s1_k_r    <= k_r;
          end else if (!s2_val_r || s2_dist_r > acc_r) begin
            s2_dist_r <= acc_r;
            s2_dev_r  <= dev;
            s2_k_r    <= k_r;
          end
        end
        default: ;
      endcase
    end
  end

`include "diagonal_line_stepper_top_macros.svh"

  `DLS_ASSERT_SAME(a_ready_excl, clk, rst_n, in_tready, !out_tvalid)
  `DLS_ASSERT_SAME(a_done_dir, clk, rst_n, out_tvalid && out_tuser, out_tdata[2:0] == dls_pkg::DIR_NONE)
  `DLS_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `DLS_ASSERT_NEXT(a_out_release, clk, rst_n, out_tvalid && out_tready, in_tready)

endmodule

### sv/dls_div.sv
// Restoring divider for the slope quotient, one quotient bit per cycle.
module dls_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dls_pkg::dls_div_req_t            req,
  output logic                             done,
  output logic [dls_pkg::QUO_W-1:0]        quo
);

  localparam int CNT_W = $clog2(dls_pkg::QUO_W + 1);

  logic [CNT_W-1:0]          cnt_r;
  logic                      run_r;
  logic                      first_r;
  logic                      done_r;
  logic [dls_pkg::DIV_W:0]   rem_r;
  logic [dls_pkg::DIV_W-1:0] den_r;
  logic [dls_pkg::QUO_W-1:0] quo_r;
  logic [dls_pkg::DIV_W:0]   trial;

  // Shift the partial remainder except on the leading bit
  assign trial = first_r ? rem_r : {rem_r[dls_pkg::DIV_W-1:0], 1'b0};

  // Control: count down the quotient bits and flag done after the last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(dls_pkg::QUO_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: compare and subtract
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r   <= {1'b0, req.num};
      den_r   <= req.den;
      quo_r   <= '0;
      first_r <= 1'b1;
    end else if (run_r) begin
      first_r <= 1'b0;
      if (trial >= {1'b0, den_r}) begin
        rem_r <= trial - {1'b0, den_r};
        quo_r <= {quo_r[dls_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        quo_r <= {quo_r[dls_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  // Zero over zero gives a zero slope
  assign quo  = (den_r == '0) ? '0 : quo_r;

endmodule

### sv/dls_mul.sv
// Shared signed multiplier with a registered product.
module dls_mul (
  input  logic                                clk,
  input  logic signed [dls_pkg::MUL_W-1:0]    a,
  input  logic signed [dls_pkg::MUL_W-1:0]    b,
  output logic signed [dls_pkg::PROD_W-1:0]   p
);

  logic signed [dls_pkg::PROD_W-1:0] p_r;

  // Register the product for use in the next cycle
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule
